// ===== hdl/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker package
// Shared types, constants and the ones' complement adder used by the
// header checker modules.
// ----------------------------------------------------------------------------
package ihc_pkg;

	// Field widths.
	localparam int WORD_W   = 16;
	localparam int ADDR_W   = 32;
	localparam int IHL_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int VERDICT_W = 3;

	// Protocol constants.
	localparam logic [3:0]        IPV4_VERSION   = 4'd4;
	localparam logic [IHL_W-1:0]  MIN_IHL        = 4'd5;
	localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 32'hffff_ffff;
	localparam logic [WORD_W-1:0] CHECKSUM_GOOD  = 16'hffff;

	// Halfword positions inside the header.
	localparam logic [COUNT_W-1:0] TTL_POS       = 5'd4;
	localparam logic [COUNT_W-1:0] DEST_HIGH_POS = 5'd8;
	localparam logic [COUNT_W-1:0] DEST_LOW_POS  = 5'd9;

	// Verdict codes.
	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ACCEPT   = 3'd0,
		VERDICT_VERSION  = 3'd1,
		VERDICT_HDRLEN   = 3'd2,
		VERDICT_TTL      = 3'd3,
		VERDICT_DEST     = 3'd4,
		VERDICT_CHECKSUM = 3'd5
	} verdict_t;

	// One input transaction.
	typedef struct packed {
		logic [WORD_W-1:0] header_word;
		logic              start_req;
	} hdr_item_t;

	// One result transaction.
	typedef struct packed {
		verdict_t           verdict;
		logic [IHL_W-1:0]   header_words;
	} hdr_result_t;

	// Ones' complement addition with end-around carry.
	function automatic logic [WORD_W-1:0] ones_add(
		input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b
	);
		logic [WORD_W:0] sum;
		logic [WORD_W:0] folded;
		sum    = {1'b0, a} + {1'b0, b};
		folded = {1'b0, sum[WORD_W-1:0]} + {{WORD_W{1'b0}}, sum[WORD_W]};
		return folded[WORD_W-1:0];
	endfunction

endpackage

// ===== hdl/ihc_in_reg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker input register
// Captures one header halfword per cycle while hdr_stall is low and holds it until the checking
// logic consumes it.
// ----------------------------------------------------------------------------
module ihc_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hdr_valid,
	output logic              hdr_stall,
	input  ihc_pkg::hdr_item_t item,
	input  logic              advance,
	output logic              valid_s1,
	output ihc_pkg::hdr_item_t item_s1
);
	import ihc_pkg::*;

	logic load;

	// The register is free when empty or when its content moves on this cycle.
	assign hdr_stall = valid_s1 & ~advance;
	assign load      = hdr_valid & ~hdr_stall;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= hdr_valid;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== hdl/ihc_check.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker core
// Keeps the running checksum and header state, and decides the verdict for
// each halfword that is consumed.
// ----------------------------------------------------------------------------
module ihc_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  ihc_pkg::hdr_item_t         item_s1,
	input  logic [ihc_pkg::ADDR_W-1:0] local_address_q,
	output logic                       res_fire,
	output ihc_pkg::hdr_result_t       result
);
	import ihc_pkg::*;

	logic [WORD_W-1:0]  running_sum_q, running_sum_d;
	logic [COUNT_W-1:0] halfword_count_q, halfword_count_d;
	logic [IHL_W-1:0]   length_words_q, length_words_d;
	logic               ttl_zero_q, ttl_zero_d;
	logic [WORD_W-1:0]  dest_high_q, dest_high_d;
	logic               dest_mismatch_q, dest_mismatch_d;
	logic               busy_q, busy_d;

	logic [3:0]         version;
	logic [IHL_W-1:0]   ihl;
	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  sum_next;
	logic [ADDR_W-1:0]  dest;
	logic [COUNT_W:0]   count_plus;
	logic [COUNT_W:0]   total_halfwords;
	logic               last;

	assign word            = item_s1.header_word;
	assign version         = word[15:12];
	assign ihl             = word[11:8];
	assign sum_next        = ones_add(running_sum_q, word);
	assign dest            = {dest_high_q, word};
	assign count_plus      = {1'b0, halfword_count_q} + 6'd1;
	assign total_halfwords = {1'b0, length_words_q, 1'b0};
	assign last            = count_plus >= total_halfwords;

	// Next state and result for the halfword in the input register.
	always_comb begin
		running_sum_d    = running_sum_q;
		halfword_count_d = halfword_count_q;
		length_words_d   = length_words_q;
		ttl_zero_d       = ttl_zero_q;
		dest_high_d      = dest_high_q;
		dest_mismatch_d  = dest_mismatch_q;
		busy_d           = busy_q;
		res_fire         = 1'b0;
		result.verdict      = VERDICT_ACCEPT;
		result.header_words = length_words_q;

		if (item_s1.start_req) begin
			// A start always abandons any header in progress.
			busy_d = 1'b0;
			if (version != IPV4_VERSION || ihl < MIN_IHL) begin
				res_fire            = 1'b1;
				result.verdict      = (version != IPV4_VERSION) ? VERDICT_VERSION
				                                                : VERDICT_HDRLEN;
				result.header_words = ihl;
			end else begin
				busy_d           = 1'b1;
				running_sum_d    = word;
				halfword_count_d = 5'd1;
				length_words_d   = ihl;
				ttl_zero_d       = 1'b0;
				dest_high_d      = '0;
				dest_mismatch_d  = 1'b0;
			end
		end else if (busy_q) begin
			running_sum_d = sum_next;

			// Capture the fields that the later checks need.
			if (halfword_count_q == TTL_POS) begin
				ttl_zero_d = (word[15:8] == 8'd0);
			end else if (halfword_count_q == DEST_HIGH_POS) begin
				dest_high_d = word;
			end else if (halfword_count_q == DEST_LOW_POS) begin
				dest_mismatch_d = (dest != local_address_q) && (dest != BROADCAST_ADDR);
			end

			// On the last halfword the checks are applied in priority order.
			if (last) begin
				busy_d   = 1'b0;
				res_fire = 1'b1;
				priority if (ttl_zero_d) begin
					result.verdict = VERDICT_TTL;
				end else if (dest_mismatch_d) begin
					result.verdict = VERDICT_DEST;
				end else if (sum_next != CHECKSUM_GOOD) begin
					result.verdict = VERDICT_CHECKSUM;
				end else begin
					result.verdict = VERDICT_ACCEPT;
				end
			end else begin
				halfword_count_d = count_plus[COUNT_W-1:0];
			end
		end
	end

	// Header state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q    <= '0;
			halfword_count_q <= '0;
			length_words_q   <= '0;
			ttl_zero_q       <= 1'b0;
			dest_high_q      <= '0;
			dest_mismatch_q  <= 1'b0;
			busy_q           <= 1'b0;
		end else if (advance) begin
			running_sum_q    <= running_sum_d;
			halfword_count_q <= halfword_count_d;
			length_words_q   <= length_words_d;
			ttl_zero_q       <= ttl_zero_d;
			dest_high_q      <= dest_high_d;
			dest_mismatch_q  <= dest_mismatch_d;
			busy_q           <= busy_d;
		end
	end

endmodule

// ===== hdl/ihc_out_reg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker output register
// Holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module ihc_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ihc_pkg::hdr_result_t result,
	input  logic                 res_stall,
	output logic                 res_valid,
	output logic                 free,
	output ihc_pkg::hdr_result_t result_q
);
	import ihc_pkg::*;

	// The register can take a new verdict when empty or being drained.
	assign free = ~res_valid | ~res_stall;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (free) begin
			res_valid <= load;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// ===== hdl/ipv4_header_checker_unit.sv =====
// ----------------------------------------------------------------------------
// IPv4 header checker
// Checks version, header length, TTL, destination and checksum of IPv4
// headers that arrive as 16-bit halfwords.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: header_word and start_req with hdr_valid and hdr_stall.
//   A transaction with start_req set begins a new header; halfwords outside
//   a header are dropped. Output channel: verdict and header_words with
//   res_valid and res_stall, at most one transaction per header.
//   The user must write local_address with local_address_we only while the
//   block is idle; the block does not enforce this. Throughput is one
//   halfword per cycle while no verdict waits for the output register. The
//   deciding halfword waits in the input register; its verdict then goes to
//   the output register. A bad version or header length is decided on the
//   first halfword; otherwise the verdict follows halfword 2*IHL-1.
//   When the receiver stalls, the verdict is held in the output register;
//   halfwords that give no verdict still move on, and the input stalls only
//   when a verdict must wait for the output register.
//   Reset clears all header state and the local address to zero; the block
//   then waits for a start.
// ----------------------------------------------------------------------------
module ipv4_header_checker_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       hdr_valid,
	output logic                       hdr_stall,
	input  logic [ihc_pkg::WORD_W-1:0] header_word,
	input  logic                       start_req,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [ihc_pkg::VERDICT_W-1:0] verdict,
	output logic [ihc_pkg::IHL_W-1:0]  header_words,
	input  logic                       local_address_we,
	input  logic [ihc_pkg::ADDR_W-1:0] local_address
);
	import ihc_pkg::*;

	hdr_item_t   item;
	hdr_item_t   item_s1;
	hdr_result_t result;
	hdr_result_t result_q;
	logic        valid_s1;
	logic        advance;
	logic        res_fire;
	logic        out_free;
	logic [ADDR_W-1:0] local_address_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (local_address_we) begin
			local_address_q <= local_address;
		end
	end

	assign item.header_word = header_word;
	assign item.start_req   = start_req;

	// A halfword is consumed unless its verdict must wait for the output register.
	assign advance = valid_s1 & (out_free | ~res_fire);

	ihc_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.item      (item),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	ihc_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item_s1         (item_s1),
		.local_address_q (local_address_q),
		.res_fire        (res_fire),
		.result          (result)
	);

	ihc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance & res_fire),
		.result    (result),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.free      (out_free),
		.result_q  (result_q)
	);

	assign verdict      = result_q.verdict;
	assign header_words = result_q.header_words;

endmodule

// ===== tb/sv/ihc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header checker verification package
// Holds the verdict scoreboard. It tracks the header being received, works
// out the verdict that each accepted halfword causes, and compares every
// result transaction with the oldest verdict still outstanding.
// ----------------------------------------------------------------------------
package ihc_tb_pkg;

	import ihc_pkg::*;

	// Ones' complement add of two halfwords with the carry wrapped back in.
	function automatic logic [WORD_W-1:0] ones_sum16(
		input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b
	);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		s = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
		return s[WORD_W-1:0];
	endfunction

	class header_scoreboard;

		// Shadow of the local address register.
		logic [ADDR_W-1:0]  local_addr;

		// Shadow of the header that is being received.
		logic [WORD_W-1:0]  csum;
		logic [COUNT_W-1:0] pos;
		logic [IHL_W-1:0]   hdr_len;
		logic [WORD_W-1:0]  dest_hi;
		bit                 in_header;
		bit                 ttl_zero;
		bit                 dest_bad;

		// Verdicts that are owed by the block, oldest first.
		hdr_result_t        expected_verdicts[$];

		int                 mismatches;
		int                 words_seen;
		int                 verdicts_seen;
		int                 by_code[8];

		function new();
			local_addr    = '0;
			csum          = '0;
			pos           = '0;
			hdr_len       = '0;
			dest_hi       = '0;
			in_header     = 1'b0;
			ttl_zero      = 1'b0;
			dest_bad      = 1'b0;
			mismatches    = 0;
			words_seen    = 0;
			verdicts_seen = 0;
			foreach (by_code[i])
				by_code[i] = 0;
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			$display("MISMATCH: %s", msg);
		endtask

		// Advance the header state by one accepted input transaction and queue
		// the verdict it causes, if any.
		function void note_halfword(input logic [WORD_W-1:0] word, input logic start);
			logic [3:0]        ver;
			logic [IHL_W-1:0]  ihl;
			logic [ADDR_W-1:0] dest;
			hdr_result_t       res;
			words_seen++;
			if (start) begin
				ver       = word[15:12];
				ihl       = word[11:8];
				in_header = 1'b0;
				// A bad version or a short header is judged on the first halfword.
				if (ver != IPV4_VERSION || ihl < MIN_IHL) begin
					res.verdict      = (ver != IPV4_VERSION) ? VERDICT_VERSION : VERDICT_HDRLEN;
					res.header_words = ihl;
					expected_verdicts.push_back(res);
					return;
				end
				in_header = 1'b1;
				csum      = word;
				pos       = 5'd1;
				hdr_len   = ihl;
				ttl_zero  = 1'b0;
				dest_hi   = '0;
				dest_bad  = 1'b0;
				return;
			end
			// Halfwords outside a header are dropped.
			if (!in_header)
				return;
			csum = ones_sum16(csum, word);
			if (pos == TTL_POS) begin
				ttl_zero = (word[15:8] == 8'd0);
			end else if (pos == DEST_HIGH_POS) begin
				dest_hi = word;
			end else if (pos == DEST_LOW_POS) begin
				dest     = {dest_hi, word};
				dest_bad = (dest != local_addr) && (dest != BROADCAST_ADDR);
			end
			// The last halfword of the header closes it with a verdict.
			if (int'(pos) + 1 >= 2 * int'(hdr_len)) begin
				if (ttl_zero)
					res.verdict = VERDICT_TTL;
				else if (dest_bad)
					res.verdict = VERDICT_DEST;
				else if (csum != CHECKSUM_GOOD)
					res.verdict = VERDICT_CHECKSUM;
				else
					res.verdict = VERDICT_ACCEPT;
				res.header_words = hdr_len;
				expected_verdicts.push_back(res);
				in_header = 1'b0;
				return;
			end
			pos = pos + 5'd1;
		endfunction

		// Compare one result transaction with the oldest outstanding verdict.
		task check_verdict(input logic [VERDICT_W-1:0] v, input logic [IHL_W-1:0] hw);
			hdr_result_t res;
			if (expected_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict %0d (ihl %0d) with no header pending", v, hw));
				return;
			end
			res = expected_verdicts.pop_front();
			verdicts_seen++;
			by_code[res.verdict]++;
			if (v !== res.verdict)
				report_mismatch($sformatf("verdict %0d, expected %0d", v, res.verdict));
			if (hw !== res.header_words)
				report_mismatch($sformatf("header_words %0d, expected %0d", hw, res.header_words));
		endtask

	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header checker testbench
// Feeds directed and random IPv4 headers (good, corrupted, truncated, bad
// version or length, stray halfwords) through the checker under several
// local addresses, with random gaps and receiver stalls, and checks every
// verdict against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

	import ihc_pkg::*;
	import ihc_tb_pkg::*;

	localparam int PHASE_ITEMS  = 180;
	localparam int PHASES       = 7;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 hdr_valid;
	logic                 hdr_stall;
	logic [WORD_W-1:0]    header_word;
	logic                 start_req;
	logic                 res_valid;
	logic                 res_stall;
	logic [VERDICT_W-1:0] verdict;
	logic [IHL_W-1:0]     header_words;
	logic                 local_address_we;
	logic [ADDR_W-1:0]    local_address;

	header_scoreboard     sb;
	int                   items_sent;
	int                   cycles = 0;
	bit                   in_gaps;
	bit                   out_stalls;

	ipv4_header_checker_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.hdr_valid        (hdr_valid),
		.hdr_stall        (hdr_stall),
		.header_word      (header_word),
		.start_req        (start_req),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.verdict          (verdict),
		.header_words     (header_words),
		.local_address_we (local_address_we),
		.local_address    (local_address)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Run stopped by the cycle limit after %0d cycles.", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Watch both channels; a transaction moves when valid is high and stall low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hdr_valid && !hdr_stall)
				sb.note_halfword(header_word, start_req);
			if (res_valid && !res_stall)
				sb.check_verdict(verdict, header_words);
		end
	end

	// Receiver stalls: mostly short bursts, now and then a long one.
	initial begin : stall_gen
		int len;
		forever begin
			if (out_stalls && $urandom_range(0, 2) == 0) begin
				res_stall = 1'b1;
				len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
			end else begin
				res_stall = 1'b0;
				len = $urandom_range(1, 6);
			end
			repeat (len) @(negedge clk);
		end
	end

	// Sender gap before a transaction: mostly none or short, a few long.
	task automatic idle_gap();
		int n;
		int r;
		n = 0;
		if (in_gaps) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				n = $urandom_range(5, 20);
			else if (r >= 60)
				n = $urandom_range(1, 3);
		end
		repeat (n) begin
			@(negedge clk);
			hdr_valid = 1'b0;
		end
	endtask

	// Offer one halfword and hold it until it is taken.
	task automatic send_item(input logic [WORD_W-1:0] word, input logic start, input bit counted);
		idle_gap();
		@(negedge clk);
		hdr_valid   = 1'b1;
		header_word = word;
		start_req   = start;
		do @(posedge clk); while (hdr_stall);
		if (counted)
			items_sent++;
	endtask

	// Build a header with a correct checksum, then apply the requested faults
	// and send its first cut halfwords.
	task automatic send_header(input logic [IHL_W-1:0] ihl, input int dest_kind,
			input bit ttl0, input bit bad_csum, input int cut);
		logic [WORD_W-1:0] hw[30];
		logic [ADDR_W-1:0] dst;
		logic [WORD_W-1:0] s;
		int                n;
		n = 2 * int'(ihl);
		for (int i = 0; i < n; i++)
			hw[i] = 16'($urandom);
		hw[0]       = {IPV4_VERSION, ihl, hw[0][7:0]};
		hw[4][15:8] = ttl0 ? 8'd0 : 8'($urandom_range(1, 255));
		case (dest_kind)
			0: dst = sb.local_addr;
			1: dst = BROADCAST_ADDR;
			default: dst = $urandom;
		endcase
		hw[8] = dst[31:16];
		hw[9] = dst[15:0];
		hw[5] = '0;
		s     = '0;
		for (int i = 0; i < n; i++)
			s = ones_sum16(s, hw[i]);
		hw[5] = ~s;
		if (bad_csum)
			hw[5] = hw[5] ^ 16'($urandom_range(1, 65535));
		for (int i = 0; i < n && i < cut; i++)
			send_item(hw[i], i == 0, 1'b1);
	endtask

	// Header length: mostly the minimum, sometimes a few options, rarely long.
	function automatic logic [IHL_W-1:0] pick_ihl();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return MIN_IHL;
		else if (r < 90)
			return 4'($urandom_range(6, 8));
		else
			return 4'($urandom_range(9, 15));
	endfunction

	// One random stimulus step, weighted toward well-formed headers.
	task automatic random_step();
		int               r;
		int               dk;
		logic [IHL_W-1:0] ihl;
		logic [3:0]       ver;
		r = $urandom_range(0, 99);
		if (r < 72) begin
			dk = $urandom_range(0, 9);
			dk = (dk < 6) ? 0 : (dk < 8) ? 1 : 2;
			send_header(pick_ihl(), dk, $urandom_range(0, 9) == 0,
				$urandom_range(0, 5) == 0, 30);
		end else if (r < 80) begin
			// Header cut short; the next start abandons it.
			ihl = pick_ihl();
			send_header(ihl, 0, 1'b0, 1'b0, $urandom_range(1, 2 * int'(ihl) - 1));
		end else if (r < 88) begin
			if ($urandom_range(0, 1) == 1) begin
				ver = 4'($urandom_range(5, 19));
				ihl = 4'($urandom);
			end else begin
				ver = IPV4_VERSION;
				ihl = 4'($urandom_range(0, 4));
			end
			send_item({ver, ihl, 8'($urandom)}, 1'b1, 1'b1);
		end else if (r < 94) begin
			repeat ($urandom_range(1, 4))
				send_item(16'($urandom), 1'b0, 1'b0);
		end else begin
			send_item(16'($urandom), 1'($urandom_range(0, 1)), 1'b1);
		end
	endtask

	// Let the block go quiet: every verdict in, then a few spare cycles.
	task automatic drain();
		@(negedge clk);
		hdr_valid = 1'b0;
		while (sb.expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_local_address(input logic [ADDR_W-1:0] addr);
		@(negedge clk);
		local_address_we = 1'b1;
		local_address    = addr;
		@(negedge clk);
		local_address_we = 1'b0;
		sb.local_addr    = addr;
	endtask

	initial begin : stimulus
		int                target;
		logic [ADDR_W-1:0] addr;
		arst_n           = 1'b0;
		hdr_valid        = 1'b0;
		header_word      = '0;
		start_req        = 1'b0;
		local_address_we = 1'b0;
		local_address    = '0;
		in_gaps          = 1'b0;
		out_stalls       = 1'b0;
		items_sent       = 0;
		sb               = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: early verdicts at the field extremes, a stray halfword,
		// a header abandoned by a new start, a header with options, and a
		// halfword after the verdict.
		send_item(16'h0000, 1'b1, 1'b1);
		send_item(16'hffff, 1'b1, 1'b1);
		send_item(16'h4400, 1'b1, 1'b1);
		send_item(16'h4000, 1'b1, 1'b1);
		send_item(16'h5500, 1'b1, 1'b1);
		send_item(16'h1234, 1'b0, 1'b0);
		send_header(MIN_IHL, 0, 1'b0, 1'b0, 3);
		send_header(4'd6, 0, 1'b0, 1'b0, 30);
		send_item(16'hffff, 1'b0, 1'b0);
		drain();

		// Random phases, each under its own local address and one of three idling patterns.
		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				1: addr = BROADCAST_ADDR;
				2: addr = 32'h0000_0001;
				4: addr = 32'h8000_0000;
				7: addr = '0;
				default: addr = $urandom;
			endcase
			set_local_address(addr);
			in_gaps    = (p % 3 != 0);
			out_stalls = (p % 3 != 0) || (p == 6);
			target     = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_step();
			drain();
		end

		$display("Ran %0d header halfwords and %0d verdicts over %0d local addresses.",
			sb.words_seen, sb.verdicts_seen, PHASES + 1);
		$display("Verdicts: accept %0d, version %0d, length %0d, ttl %0d, dest %0d, csum %0d.",
			sb.by_code[VERDICT_ACCEPT], sb.by_code[VERDICT_VERSION],
			sb.by_code[VERDICT_HDRLEN], sb.by_code[VERDICT_TTL],
			sb.by_code[VERDICT_DEST], sb.by_code[VERDICT_CHECKSUM]);
		if (sb.mismatches == 0 && sb.expected_verdicts.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
